[rtl/spq_pkg.sv]
// Package with the shared types and constants of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int PAYLOAD_BITS_DEF  = 32;
  localparam int MSG_LEN_MAX_DEF   = 255;

  localparam int QLIM_W   = 7;
  localparam int MLEN_W   = 8;
  localparam int CFG_DW   = 8;
  localparam int CFG_IW   = 1;

  localparam logic [QLIM_W-1:0] QLIM_RESET = 7'd64;
  localparam logic [MLEN_W-1:0] MLEN_RESET = 8'd255;

  localparam logic [CFG_IW-1:0] CFG_QUEUE_LIMIT   = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_MSG_LEN_LIMIT = 1'b1;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_TOO_LONG  = 2'd2,
    STAT_POP_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_POPLD,
    ST_DONE
  } bk_state_t;

  typedef struct packed {
    logic is_pop;
    logic too_long;
  } cmd_ctl_t;

endpackage

[rtl/stable_priority_queue_top.sv]
// Top level of the stable priority queue: configuration registers and the two halves.
//
// Input words arrive on in_valid/in_stall: action 0 pushes (priority_req, payload)
// when the queue is under both queue_limit and CAPACITY and msg_length fits the limits, action 1
// pops the head. Each input word yields exactly one output word on out_valid/out_stall
// with the head after the operation, the entry count and a status code.
// A two-word command queue sits behind the input, so new words are taken while the
// engine works and while a result waits in the output register.
// The engine keeps entries sorted in a ring buffer memory with one write and one
// registered read port. A dropped push, a pop that empties the queue, a pop on empty
// and a push in front of the head or into an empty queue go from the idle state
// straight to the done state; a pop that needs the new head first reads it in the
// load state; any other push walks through the memory in the shift state, moving one
// entry per cycle past the k stored entries with a larger priority.
// The engine takes a new command only when idle, after the last result is registered.
// Reset empties the queue and sets queue_limit to 64 and msg_len_limit to 255.
// While out_stall is high the result is held; the engine then waits with its next
// result and the command queue fills, after which in_stall rises.
// Configuration words are always taken (cfg_ready is high) and should only be
// written while the block is idle.
`timescale 1ns / 1ps

module stable_priority_queue_top #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
  parameter int MSG_LEN_MAX   = spq_pkg::MSG_LEN_MAX_DEF,
  localparam int CW           = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spq_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [spq_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [PRIORITY_BITS-1:0]   priority_req,
  input  logic        [PAYLOAD_BITS-1:0]    payload,
  input  logic        [spq_pkg::MLEN_W-1:0] msg_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              head_valid,
  output logic signed [PRIORITY_BITS-1:0]   head_priority,
  output logic        [PAYLOAD_BITS-1:0]    head_payload,
  output logic        [CW-1:0]              entry_count,
  output logic        [1:0]                 status
);

  logic [spq_pkg::QLIM_W-1:0]      queue_limit;
  logic [spq_pkg::MLEN_W-1:0]      msg_len_limit;
  logic                            cmd_valid;
  logic                            cmd_take;
  spq_pkg::cmd_ctl_t               cmd_ctl;
  logic signed [PRIORITY_BITS-1:0] cmd_prio;
  logic        [PAYLOAD_BITS-1:0]  cmd_pay;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit   <= spq_pkg::QLIM_RESET;
      msg_len_limit <= spq_pkg::MLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spq_pkg::CFG_QUEUE_LIMIT: begin
          queue_limit <= cfg_data[spq_pkg::QLIM_W-1:0];
        end
        spq_pkg::CFG_MSG_LEN_LIMIT: begin
          msg_len_limit <= cfg_data[spq_pkg::MLEN_W-1:0];
        end
        default: begin
          queue_limit <= queue_limit;
        end
      endcase
    end
  end

  spq_front #(
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .MSG_LEN_MAX   (MSG_LEN_MAX)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .priority_req  (priority_req),
    .payload       (payload),
    .msg_length    (msg_length),
    .msg_len_limit (msg_len_limit),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd_ctl       (cmd_ctl),
    .cmd_prio      (cmd_prio),
    .cmd_pay       (cmd_pay)
  );

  spq_back #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_limit   (queue_limit),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd_ctl       (cmd_ctl),
    .cmd_prio      (cmd_prio),
    .cmd_pay       (cmd_pay),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .head_valid    (head_valid),
    .head_priority (head_priority),
    .head_payload  (head_payload),
    .entry_count   (entry_count),
    .status        (status)
  );

endmodule

[rtl/spq_front.sv]
// Front end: takes input words, checks the message length and queues the commands.
`timescale 1ns / 1ps

module spq_front #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
  parameter int MSG_LEN_MAX   = spq_pkg::MSG_LEN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic signed [PRIORITY_BITS-1:0] priority_req,
  input  logic        [PAYLOAD_BITS-1:0]  payload,
  input  logic        [spq_pkg::MLEN_W-1:0] msg_length,
  input  logic        [spq_pkg::MLEN_W-1:0] msg_len_limit,
  output logic                            cmd_valid,
  input  logic                            cmd_take,
  output spq_pkg::cmd_ctl_t               cmd_ctl,
  output logic signed [PRIORITY_BITS-1:0] cmd_prio,
  output logic        [PAYLOAD_BITS-1:0]  cmd_pay
);

  spq_pkg::cmd_ctl_t               q_ctl  [spq_pkg::CMDQ_DEPTH];
  logic signed [PRIORITY_BITS-1:0] q_prio [spq_pkg::CMDQ_DEPTH];
  logic        [PAYLOAD_BITS-1:0]  q_pay  [spq_pkg::CMDQ_DEPTH];
  logic [spq_pkg::CMDQ_AW-1:0]     wr_ptr;
  logic [spq_pkg::CMDQ_AW-1:0]     rd_ptr;
  logic [spq_pkg::CMDQ_AW:0]       fill;
  logic                            push;
  logic                            pop;
  spq_pkg::cmd_ctl_t               new_ctl;

  assign in_stall  = (fill == (spq_pkg::CMDQ_AW + 1)'(spq_pkg::CMDQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_take;

  always_comb begin
    new_ctl.is_pop   = (action == spq_pkg::ACT_POP);
    new_ctl.too_long = (msg_length > msg_len_limit) ||
                       ({8'd0, msg_length} > 16'(MSG_LEN_MAX));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl[wr_ptr]  <= new_ctl;
      q_prio[wr_ptr] <= priority_req;
      q_pay[wr_ptr]  <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign cmd_ctl  = q_ctl[rd_ptr];
  assign cmd_prio = q_prio[rd_ptr];
  assign cmd_pay  = q_pay[rd_ptr];

endmodule

[rtl/spq_back.sv]
// Back end: sorted ring store, insertion walk, pop and the result register.
`timescale 1ns / 1ps

module spq_back #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
  localparam int CW           = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [spq_pkg::QLIM_W-1:0]        queue_limit,
  input  logic                              cmd_valid,
  output logic                              cmd_take,
  input  spq_pkg::cmd_ctl_t                 cmd_ctl,
  input  logic signed [PRIORITY_BITS-1:0]   cmd_prio,
  input  logic        [PAYLOAD_BITS-1:0]    cmd_pay,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              head_valid,
  output logic signed [PRIORITY_BITS-1:0]   head_priority,
  output logic        [PAYLOAD_BITS-1:0]    head_payload,
  output logic        [CW-1:0]              entry_count,
  output logic        [1:0]                 status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = (CW > spq_pkg::QLIM_W) ? CW : spq_pkg::QLIM_W;
  localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;

  spq_pkg::bk_state_t state;
  spq_pkg::bk_state_t state_next;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic [AW-1:0]                   head_ptr;
  logic [CW-1:0]                   count;
  logic signed [PRIORITY_BITS-1:0] hd_prio;
  logic        [PAYLOAD_BITS-1:0]  hd_pay;
  logic signed [PRIORITY_BITS-1:0] new_prio;
  logic        [PAYLOAD_BITS-1:0]  new_pay;
  logic [AW-1:0]                   rd_idx;
  spq_pkg::status_t                op_status;

  logic                            res_hv;
  logic signed [PRIORITY_BITS-1:0] res_prio;
  logic        [PAYLOAD_BITS-1:0]  res_pay;
  logic [CW-1:0]                   res_count;
  spq_pkg::status_t                res_status;

  logic [LW-1:0]                   eff_limit;
  logic                            is_full;
  logic                            is_empty;
  logic                            ins_front;
  logic signed [PRIORITY_BITS-1:0] rd_prio;
  logic                            rd_gt;
  logic [AW:0]                     tail_sum;
  logic [AW-1:0]                   tail_idx;
  logic                            res_load;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  assign eff_limit = (LW'(queue_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(queue_limit);
  assign is_full   = (LW'(count) >= eff_limit);
  assign is_empty  = (count == '0);
  assign ins_front = (cmd_prio < hd_prio);
  assign rd_prio   = rd_data[EW-1 -: PRIORITY_BITS];
  assign rd_gt     = (rd_prio > new_prio);
  assign tail_sum  = {1'b0, head_ptr} + {1'b0, AW'(count - 1'b1)};
  assign tail_idx  = (tail_sum >= (AW + 1)'(CAPACITY)) ?
                     AW'(tail_sum - (AW + 1)'(CAPACITY)) : AW'(tail_sum);
  assign res_load  = (state == spq_pkg::ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_ctl.is_pop) begin
            if (!is_empty && (count != CW'(1))) begin
              state_next = spq_pkg::ST_POPLD;
            end else begin
              state_next = spq_pkg::ST_DONE;
            end
          end else if (!is_full && !cmd_ctl.too_long && !is_empty && !ins_front) begin
            state_next = spq_pkg::ST_SHIFT;
          end else begin
            state_next = spq_pkg::ST_DONE;
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        if (!rd_gt) begin
          state_next = spq_pkg::ST_DONE;
        end
      end
      spq_pkg::ST_POPLD: begin
        state_next = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_DONE: begin
        if (res_load) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_take  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_ptr;
    mem_wdata = {cmd_prio, cmd_pay};
    rd_addr   = rd_idx;
    case (state)
      spq_pkg::ST_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_ctl.is_pop) begin
          rd_addr = idx_inc(head_ptr);
        end else begin
          rd_addr = tail_idx;
          if (cmd_valid && !is_full && !cmd_ctl.too_long) begin
            if (is_empty) begin
              mem_we = 1'b1;
            end else if (ins_front) begin
              mem_we    = 1'b1;
              mem_waddr = idx_dec(head_ptr);
            end
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc(rd_idx);
        rd_addr   = idx_dec(rd_idx);
        mem_wdata = rd_gt ? rd_data : {new_prio, new_pay};
      end
      spq_pkg::ST_POPLD: begin
        rd_addr = rd_idx;
      end
      spq_pkg::ST_DONE: begin
        rd_addr = rd_idx;
      end
      default: begin
        rd_addr = rd_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      count     <= '0;
      head_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        spq_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd_ctl.is_pop) begin
              if (!is_empty) begin
                head_ptr <= idx_inc(head_ptr);
                count    <= count - 1'b1;
              end
            end else if (!is_full && !cmd_ctl.too_long) begin
              if (is_empty) begin
                count <= count + 1'b1;
              end else if (ins_front) begin
                head_ptr <= idx_dec(head_ptr);
                count    <= count + 1'b1;
              end
            end
          end
        end
        spq_pkg::ST_SHIFT: begin
          if (!rd_gt) begin
            count <= count + 1'b1;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      spq_pkg::ST_IDLE: begin
        rd_idx   <= cmd_ctl.is_pop ? idx_inc(head_ptr) : tail_idx;
        new_prio <= cmd_prio;
        new_pay  <= cmd_pay;
        if (cmd_ctl.is_pop) begin
          op_status <= is_empty ? spq_pkg::STAT_POP_EMPTY : spq_pkg::STAT_DONE;
        end else if (is_full) begin
          op_status <= spq_pkg::STAT_FULL;
        end else if (cmd_ctl.too_long) begin
          op_status <= spq_pkg::STAT_TOO_LONG;
        end else begin
          op_status <= spq_pkg::STAT_DONE;
          if (cmd_valid && (is_empty || ins_front)) begin
            hd_prio <= cmd_prio;
            hd_pay  <= cmd_pay;
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        if (rd_gt) begin
          rd_idx <= idx_dec(rd_idx);
        end
      end
      spq_pkg::ST_POPLD: begin
        hd_prio <= rd_prio;
        hd_pay  <= rd_data[PAYLOAD_BITS-1:0];
      end
      spq_pkg::ST_DONE: begin
        if (res_load) begin
          res_hv     <= !is_empty;
          res_prio   <= is_empty ? '0 : hd_prio;
          res_pay    <= is_empty ? '0 : hd_pay;
          res_count  <= count;
          res_status <= op_status;
        end
      end
      default: begin
        rd_idx <= rd_idx;
      end
    endcase
  end

  assign head_valid    = res_hv;
  assign head_priority = res_prio;
  assign head_payload  = res_pay;
  assign entry_count   = res_count;
  assign status        = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("Entry count is above the capacity.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) || (count == $past(count) + 1'b1) ||
                    (count == $past(count) - 1'b1))
    else $error("Entry count moved by more than one.");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::ST_SHIFT) |-> !is_empty)
    else $error("Insertion walk runs on an empty queue.");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_status == spq_pkg::STAT_POP_EMPTY) |-> (res_count == '0) && !res_hv)
    else $error("Pop on empty reported with entries held.");

  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_hv == (res_count != '0)))
    else $error("Head flag disagrees with the entry count.");

endmodule

[tb/sv/tb_stable_priority_queue_top.sv]
// Self-checking testbench for the stable priority queue with a sorted shadow queue as predictor.
`timescale 1ns / 1ps

module tb_stable_priority_queue_top;

  localparam int CAPACITY   = spq_pkg::CAPACITY_DEF;
  localparam int PRIO_W     = spq_pkg::PRIORITY_BITS_DEF;
  localparam int PAY_W      = spq_pkg::PAYLOAD_BITS_DEF;
  localparam int MSG_MAX    = spq_pkg::MSG_LEN_MAX_DEF;
  localparam int CW         = $clog2(CAPACITY + 1);
  localparam int LONG_HOLD  = 200;
  localparam int DRAIN_WAIT = 80;

  typedef struct {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]         pay;
    logic [CW-1:0]            count;
    spq_pkg::status_t         status;
  } head_report_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [spq_pkg::CFG_IW-1:0] cfg_index;
  logic [spq_pkg::CFG_DW-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       action;
  logic signed [PRIO_W-1:0]   priority_req;
  logic [PAY_W-1:0]           payload;
  logic [spq_pkg::MLEN_W-1:0] msg_length;
  logic                       out_valid;
  logic                       out_stall;
  logic                       head_valid;
  logic signed [PRIO_W-1:0]   head_priority;
  logic [PAY_W-1:0]           head_payload;
  logic [CW-1:0]              entry_count;
  logic [1:0]                 status;

  logic signed [PRIO_W-1:0]   shadow_prio[$];
  logic [PAY_W-1:0]           shadow_pay[$];
  logic [spq_pkg::QLIM_W-1:0] shadow_qlim = spq_pkg::QLIM_RESET;
  logic [spq_pkg::MLEN_W-1:0] shadow_mlen = spq_pkg::MLEN_RESET;
  head_report_t               pending_heads[$];
  int                         mismatches = 0;
  int                         burst_left = 0;
  bit                         hold_request = 0;

  stable_priority_queue_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .priority_req(priority_req),
    .payload(payload),
    .msg_length(msg_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head_valid(head_valid),
    .head_priority(head_priority),
    .head_payload(head_payload),
    .entry_count(entry_count),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic head_report_t shadow_step(input logic act,
                                               input logic signed [PRIO_W-1:0] prio,
                                               input logic [PAY_W-1:0] pay,
                                               input logic [spq_pkg::MLEN_W-1:0] len);
    head_report_t r;
    int eff_limit;
    int pos;
    eff_limit = (shadow_qlim > CAPACITY) ? CAPACITY : int'(shadow_qlim);
    r.status = spq_pkg::STAT_DONE;
    if (act == spq_pkg::ACT_PUSH) begin
      if (shadow_prio.size() >= eff_limit) begin
        r.status = spq_pkg::STAT_FULL;
      end else if (len > shadow_mlen || len > MSG_MAX) begin
        r.status = spq_pkg::STAT_TOO_LONG;
      end else begin
        pos = 0;
        while (pos < shadow_prio.size() && shadow_prio[pos] <= prio) pos++;
        shadow_prio.insert(pos, prio);
        shadow_pay.insert(pos, pay);
      end
    end else begin
      if (shadow_prio.size() == 0) begin
        r.status = spq_pkg::STAT_POP_EMPTY;
      end else begin
        void'(shadow_prio.pop_front());
        void'(shadow_pay.pop_front());
      end
    end
    r.valid = (shadow_prio.size() > 0);
    r.prio  = r.valid ? shadow_prio[0] : '0;
    r.pay   = r.valid ? shadow_pay[0] : '0;
    r.count = CW'(shadow_prio.size());
    return r;
  endfunction

  task automatic send_word(input logic act, input logic signed [PRIO_W-1:0] prio,
                           input logic [PAY_W-1:0] pay,
                           input logic [spq_pkg::MLEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    action       <= act;
    priority_req <= prio;
    payload      <= pay;
    msg_length   <= len;
    do @(posedge clk); while (in_stall);
    pending_heads.push_back(shadow_step(act, prio, pay, len));
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [spq_pkg::CFG_IW-1:0] idx,
                           input logic [spq_pkg::CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == spq_pkg::CFG_QUEUE_LIMIT) shadow_qlim = val[spq_pkg::QLIM_W-1:0];
    else shadow_mlen = val[spq_pkg::MLEN_W-1:0];
  endtask

  task automatic set_limits(input logic [spq_pkg::CFG_DW-1:0] qlim,
                            input logic [spq_pkg::CFG_DW-1:0] mlen);
    write_reg(spq_pkg::CFG_QUEUE_LIMIT, qlim);
    write_reg(spq_pkg::CFG_MSG_LEN_LIMIT, mlen);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    logic [1:0] corner;
    corner = 2'($urandom);
    case ($urandom_range(0, 3))
      0: return PRIO_W'($urandom_range(0, 6) - 3);
      1: begin
        case (corner)
          2'd0: return {1'b1, {(PRIO_W-1){1'b0}}};
          2'd1: return {1'b0, {(PRIO_W-1){1'b1}}};
          2'd2: return '0;
          default: return '1;
        endcase
      end
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  function automatic logic [spq_pkg::MLEN_W-1:0] pick_length();
    case ($urandom_range(0, 3))
      0: return spq_pkg::MLEN_W'($urandom);
      1: return shadow_mlen;
      2: return shadow_mlen + 8'd1;
      default: return spq_pkg::MLEN_W'($urandom_range(0, shadow_mlen));
    endcase
  endfunction

  task automatic send_random(input int push_pct);
    logic act;
    act = ($urandom_range(0, 99) < push_pct) ? spq_pkg::ACT_PUSH : spq_pkg::ACT_POP;
    send_word(act, pick_priority(), $urandom, pick_length());
  endtask

  task automatic run_phase(input logic [spq_pkg::CFG_DW-1:0] qlim,
                           input logic [spq_pkg::CFG_DW-1:0] mlen,
                           input int words, input int push_pct);
    set_limits(qlim, mlen);
    repeat (words) send_random(push_pct);
    drain_block();
  endtask

  task automatic test_empty_and_order();
    send_word(spq_pkg::ACT_POP, 16'sd7, 32'h1234_5678, 8'd3);
    send_word(spq_pkg::ACT_PUSH, 16'sd5, 32'h0000_00A1, 8'd255);
    send_word(spq_pkg::ACT_PUSH, 16'sd5, 32'h0000_00B2, 8'd0);
    send_word(spq_pkg::ACT_PUSH, 16'sh8000, 32'h0000_0000, 8'd1);
    send_word(spq_pkg::ACT_PUSH, 16'sh7FFF, 32'hFFFF_FFFF, 8'd128);
    send_word(spq_pkg::ACT_PUSH, 16'sd5, 32'h0000_00C3, 8'd64);
    repeat (5) send_word(spq_pkg::ACT_POP, 16'sd0, 32'h0, 8'd0);
    send_word(spq_pkg::ACT_POP, 16'sh7FFF, 32'hFFFF_FFFF, 8'd255);
    drain_block();
  endtask

  task automatic test_length_and_full();
    set_limits(8'd2, 8'd10);
    send_word(spq_pkg::ACT_PUSH, 16'sd3, 32'h0000_0011, 8'd10);
    send_word(spq_pkg::ACT_PUSH, 16'sd2, 32'h0000_0022, 8'd11);
    send_word(spq_pkg::ACT_PUSH, -16'sd4, 32'h0000_0033, 8'd10);
    send_word(spq_pkg::ACT_PUSH, 16'sd1, 32'h0000_0044, 8'd200);
    send_word(spq_pkg::ACT_POP, 16'sd0, 32'h0, 8'd0);
    send_word(spq_pkg::ACT_POP, 16'sd0, 32'h0, 8'd0);
    drain_block();
    set_limits(8'd0, 8'd0);
    send_word(spq_pkg::ACT_PUSH, 16'sd9, 32'h0000_0055, 8'd0);
    send_word(spq_pkg::ACT_POP, 16'sd0, 32'h0, 8'd0);
    drain_block();
    set_limits(8'd100, 8'd0);
    send_word(spq_pkg::ACT_PUSH, 16'sd9, 32'h0000_0066, 8'd0);
    send_word(spq_pkg::ACT_PUSH, 16'sd8, 32'h0000_0077, 8'd1);
    send_word(spq_pkg::ACT_POP, 16'sd0, 32'h0, 8'd0);
    drain_block();
  endtask

  task automatic test_random_traffic();
    run_phase(8'd64, 8'd255, 300, 55);
    run_phase(8'd127, 8'd200, 300, 85);
    run_phase(8'd8, 8'd128, 250, 60);
    run_phase(8'd1, 8'd0, 150, 50);
    run_phase(8'd33, 8'd17, 400, 50);
  endtask

  task automatic test_backpressure_fill();
    set_limits(8'd200, 8'd255);
    hold_request = 1'b1;
    repeat (300) send_random(70);
    drain_block();
  endtask

  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    head_report_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_heads.size() == 0) begin
          $error("Result word with no pending item: head_payload %0h", head_payload);
          mismatches++;
        end else begin
          want = pending_heads.pop_front();
          check_field("head_valid", 32'(want.valid), 32'(head_valid));
          check_field("head_priority", 32'(want.prio), 32'(head_priority));
          check_field("head_payload", 32'(want.pay), 32'(head_payload));
          check_field("entry_count", 32'(want.count), 32'(entry_count));
          check_field("status", 32'(want.status), 32'(status));
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= spq_pkg::CFG_QUEUE_LIMIT;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    action       <= spq_pkg::ACT_PUSH;
    priority_req <= '0;
    payload      <= '0;
    msg_length   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_order();
    test_length_and_full();
    test_random_traffic();
    test_backpressure_fill();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
